// ----- hw/rtl/ehv_pkg.sv -----
// ----------------------------------------------------------------------------
// ehv_pkg
// Shared constants and types for the executable header validator.
// ----------------------------------------------------------------------------
package ehv_pkg;

  localparam int HEADER_BYTES = 32;
  localparam int FIELD_COUNT  = 10;
  localparam int FIELD_FIRST  = 8;
  localparam int FIELD_END    = FIELD_FIRST + 2 * FIELD_COUNT;
  localparam int POS_W        = 6;
  localparam int FIELD_IDX_W  = $clog2(FIELD_COUNT);
  localparam int ADDR_W       = 3;

  localparam logic [POS_W-1:0] POS_LAST        = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_DONE        = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_VERSION_LO  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_VERSION_HI  = POS_W'(5);
  localparam logic [POS_W-1:0] POS_MAGIC_END   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_FIELD_FIRST = POS_W'(FIELD_FIRST);
  localparam logic [POS_W-1:0] POS_FIELD_END   = POS_W'(FIELD_END);

  localparam logic [3:0][7:0] MAGIC = {8'h4E, 8'h46, 8'h45, 8'h58};

  // Register indexes, selected by the word address bit of paddr.
  localparam logic REG_IMAGE_BYTES    = 1'b0;
  localparam logic REG_FORMAT_VERSION = 1'b1;

  localparam logic [15:0] IMAGE_BYTES_RESET    = 16'd0;
  localparam logic [15:0] FORMAT_VERSION_RESET = 16'd1;

  // Field slots in header order.
  localparam int F_ENTRY    = 0;
  localparam int F_CODE     = 1;
  localparam int F_DATA     = 2;
  localparam int F_ZFILL    = 3;
  localparam int F_IMP_OFF  = 4;
  localparam int F_IMP_CNT  = 5;
  localparam int F_REL_OFF  = 6;
  localparam int F_REL_CNT  = 7;
  localparam int F_STR_OFF  = 8;
  localparam int F_STR_LEN  = 9;

  typedef logic [FIELD_COUNT-1:0][15:0] field_arr_t;

  typedef struct packed {
    logic       emit;
    logic       magic_ok;
    field_arr_t fields;
  } cap_result_t;

  typedef struct packed {
    logic [15:0] image_bytes;
    logic [15:0] format_version;
  } cfg_t;

endpackage

// ----- hw/rtl/ehv_regs.sv -----
// ----------------------------------------------------------------------------
// ehv_regs
// APB configuration registers: image size and required format version.
// ----------------------------------------------------------------------------
module ehv_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ehv_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ehv_pkg::cfg_t              cfg
);
  import ehv_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_bytes    <= IMAGE_BYTES_RESET;
      cfg.format_version <= FORMAT_VERSION_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_IMAGE_BYTES:    cfg.image_bytes    <= pwdata[15:0];
        REG_FORMAT_VERSION: cfg.format_version <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_BYTES:    prdata = {16'd0, cfg.image_bytes};
      REG_FORMAT_VERSION: prdata = {16'd0, cfg.format_version};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

// ----- hw/rtl/ehv_capture.sv -----
// ----------------------------------------------------------------------------
// ehv_capture
// Input register, byte position tracking, magic and version check, and
// capture of the little-endian header fields.
// ----------------------------------------------------------------------------
module ehv_capture (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           header_byte,
  input  logic                 first_byte,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 out_busy,
  input  logic [15:0]          format_version,
  output logic                 advance,
  output ehv_pkg::cap_result_t cap
);
  import ehv_pkg::*;

  logic                   vld_r;
  logic [7:0]             byte_r;
  logic                   first_r;
  logic [POS_W-1:0]       byte_position;
  logic [POS_W-1:0]       byte_position_next;
  logic [7:0]             low_byte_hold;
  logic [7:0]             low_byte_hold_next;
  logic                   magic_version_good;
  logic                   magic_version_good_next;
  field_arr_t             fields;
  field_arr_t             fields_next;
  logic [POS_W-1:0]       pos_eff;
  logic [7:0]             low_eff;
  logic                   mvg_eff;
  logic [POS_W-1:0]       rel;
  logic [FIELD_IDX_W-1:0] field_idx;
  logic                   emit;
  logic                   blocked;

  assign pos_eff   = first_r ? '0 : byte_position;
  assign low_eff   = first_r ? 8'd0 : low_byte_hold;
  assign mvg_eff   = first_r ? 1'b1 : magic_version_good;
  assign rel       = pos_eff - POS_FIELD_FIRST;
  assign field_idx = rel[FIELD_IDX_W:1];
  assign emit      = (pos_eff == POS_LAST);
  assign blocked   = emit & out_busy;
  assign in_stall  = vld_r & blocked;
  assign advance   = vld_r & ~blocked;

  always_comb begin
    byte_position_next      = pos_eff;
    low_byte_hold_next      = low_eff;
    magic_version_good_next = mvg_eff;
    fields_next             = fields;
    if (pos_eff < POS_DONE) begin
      byte_position_next = pos_eff + POS_W'(1);
      if (pos_eff < POS_MAGIC_END) begin
        if (byte_r != MAGIC[pos_eff[1:0]]) begin
          magic_version_good_next = 1'b0;
        end
      end else if (pos_eff == POS_VERSION_LO) begin
        low_byte_hold_next = byte_r;
      end else if (pos_eff == POS_VERSION_HI) begin
        if ({byte_r, low_eff} != format_version) begin
          magic_version_good_next = 1'b0;
        end
      end else if (pos_eff >= POS_FIELD_FIRST && pos_eff < POS_FIELD_END) begin
        if (!rel[0]) begin
          low_byte_hold_next = byte_r;
        end else begin
          fields_next[field_idx] = {byte_r, low_eff};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r  <= header_byte;
      first_r <= first_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      low_byte_hold      <= 8'd0;
      magic_version_good <= 1'b1;
    end else if (advance) begin
      byte_position      <= byte_position_next;
      low_byte_hold      <= low_byte_hold_next;
      magic_version_good <= magic_version_good_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fields <= fields_next;
    end
  end

  assign cap.emit     = emit;
  assign cap.magic_ok = magic_version_good_next;
  assign cap.fields   = fields_next;

endmodule

// ----- hw/rtl/ehv_check.sv -----
// ----------------------------------------------------------------------------
// ehv_check
// Bounds and consistency checks on the captured header fields.
// ----------------------------------------------------------------------------
module ehv_check (
  input  ehv_pkg::cap_result_t cap,
  input  logic [15:0]          image_bytes,
  output logic                 header_ok
);
  import ehv_pkg::*;

  logic [18:0] img;
  logic [18:0] sect_end;
  logic [18:0] imp_end;
  logic [18:0] str_end;
  logic [18:0] rel_end;
  logic        base_ok;
  logic        imp_ok;
  logic        rel_ok;

  assign img      = {3'd0, image_bytes};
  assign sect_end = 19'(HEADER_BYTES) + {3'd0, cap.fields[F_CODE]}
                  + {3'd0, cap.fields[F_DATA]};
  assign imp_end  = {3'd0, cap.fields[F_IMP_OFF]} + {2'd0, cap.fields[F_IMP_CNT], 1'b0};
  assign str_end  = {3'd0, cap.fields[F_STR_OFF]} + {3'd0, cap.fields[F_STR_LEN]};
  assign rel_end  = {3'd0, cap.fields[F_REL_OFF]} + {1'b0, cap.fields[F_REL_CNT], 2'b00};

  assign base_ok = (img >= 19'(HEADER_BYTES)) && cap.magic_ok
                && (cap.fields[F_CODE] != 16'd0)
                && (cap.fields[F_ENTRY] < cap.fields[F_CODE])
                && (sect_end <= img);

  assign imp_ok = (cap.fields[F_IMP_CNT] == 16'd0)
               || ((cap.fields[F_STR_LEN] != 16'd0)
                && ({3'd0, cap.fields[F_IMP_OFF]} >= sect_end)
                && ({3'd0, cap.fields[F_STR_OFF]} >= sect_end)
                && (imp_end <= img)
                && (str_end <= img));

  assign rel_ok = (cap.fields[F_REL_CNT] == 16'd0)
               || (({3'd0, cap.fields[F_REL_OFF]} >= sect_end) && (rel_end <= img));

  assign header_ok = base_ok & imp_ok & rel_ok;

endmodule

// ----- hw/rtl/exec_header_validator.sv -----
// Result path: a header byte is registered on its transfer; on the last header byte the
// result is loaded into the output register when that byte leaves the input register.
// Throughput: one header byte per cycle; one result per header of HEADER_BYTES bytes.
// The input stalls only when a final byte meets a result register still held.
// Reset: synchronous, active high; clears position, pending transfers and sets the
// registers to image size 0 and format version 1.
// ----------------------------------------------------------------------------
// exec_header_validator
// Streams header bytes, checks magic, version and section bounds, and
// returns the validity flag with the ten captured header fields.
// ----------------------------------------------------------------------------
module exec_header_validator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [7:0]                 header_byte,
  input  logic                       first_byte,
  input  logic                       in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       header_ok,
  output logic [15:0]                entry_offset,
  output logic [15:0]                code_bytes,
  output logic [15:0]                data_bytes,
  output logic [15:0]                zero_fill_bytes,
  output logic [15:0]                import_table_offset,
  output logic [15:0]                import_entries,
  output logic [15:0]                reloc_table_offset,
  output logic [15:0]                reloc_entries,
  output logic [15:0]                string_table_offset,
  output logic [15:0]                string_table_bytes,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ehv_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ehv_pkg::*;

  cfg_t        cfg;
  cap_result_t cap;
  logic        advance;
  logic        ok;
  logic        load;
  field_arr_t  out_fields;

  ehv_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ehv_capture u_capture (
    .clk            (clk),
    .rst            (rst),
    .header_byte    (header_byte),
    .first_byte     (first_byte),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_busy       (out_valid & out_stall),
    .format_version (cfg.format_version),
    .advance        (advance),
    .cap            (cap)
  );

  ehv_check u_check (
    .cap         (cap),
    .image_bytes (cfg.image_bytes),
    .header_ok   (ok)
  );

  assign load = advance & cap.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      header_ok  <= ok;
      out_fields <= cap.fields;
    end
  end

  assign entry_offset        = out_fields[F_ENTRY];
  assign code_bytes          = out_fields[F_CODE];
  assign data_bytes          = out_fields[F_DATA];
  assign zero_fill_bytes     = out_fields[F_ZFILL];
  assign import_table_offset = out_fields[F_IMP_OFF];
  assign import_entries      = out_fields[F_IMP_CNT];
  assign reloc_table_offset  = out_fields[F_REL_OFF];
  assign reloc_entries       = out_fields[F_REL_CNT];
  assign string_table_offset = out_fields[F_STR_OFF];
  assign string_table_bytes  = out_fields[F_STR_LEN];

endmodule

// ----- tb/header_result_checker.sv -----
// ----------------------------------------------------------------------------
// header_result_checker
// Watches the byte, result and register ports of the header validator,
// tracks the header being assembled and the programmed registers, and
// compares every result transfer with the verdict predicted for it.
// ----------------------------------------------------------------------------
module header_result_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [7:0]                 header_byte,
  input  logic                       first_byte,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       header_ok,
  input  logic [15:0]                entry_offset,
  input  logic [15:0]                code_bytes,
  input  logic [15:0]                data_bytes,
  input  logic [15:0]                zero_fill_bytes,
  input  logic [15:0]                import_table_offset,
  input  logic [15:0]                import_entries,
  input  logic [15:0]                reloc_table_offset,
  input  logic [15:0]                reloc_entries,
  input  logic [15:0]                string_table_offset,
  input  logic [15:0]                string_table_bytes,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ehv_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int                         failures,
  output int                         pending
);
  import ehv_pkg::*;

  typedef struct packed {
    logic       ok;
    field_arr_t fields;
  } header_verdict_t;

  header_verdict_t expected_headers [$];
  logic [15:0]     image_bytes_reg;
  logic [15:0]     version_reg;
  int              position;
  logic [7:0]      low_hold;
  logic            magic_version_good;
  field_arr_t      fields;
  string           field_label [FIELD_COUNT] = '{"entry_offset", "code_bytes", "data_bytes",
    "zero_fill_bytes", "import_table_offset", "import_entries", "reloc_table_offset",
    "reloc_entries", "string_table_offset", "string_table_bytes"};

  function automatic logic layout_ok();
    int unsigned stop;
    stop = HEADER_BYTES + 32'(fields[F_CODE]) + 32'(fields[F_DATA]);
    if (image_bytes_reg < HEADER_BYTES || !magic_version_good) return 1'b0;
    if (fields[F_CODE] == 16'd0 || fields[F_ENTRY] >= fields[F_CODE]) return 1'b0;
    if (stop > image_bytes_reg) return 1'b0;
    if (fields[F_IMP_CNT] != 16'd0) begin
      if (fields[F_STR_LEN] == 16'd0) return 1'b0;
      if (fields[F_IMP_OFF] < stop || fields[F_STR_OFF] < stop) return 1'b0;
      if (32'(fields[F_IMP_OFF]) + 2 * 32'(fields[F_IMP_CNT]) > image_bytes_reg) return 1'b0;
      if (32'(fields[F_STR_OFF]) + 32'(fields[F_STR_LEN]) > image_bytes_reg) return 1'b0;
    end
    if (fields[F_REL_CNT] != 16'd0) begin
      if (fields[F_REL_OFF] < stop) return 1'b0;
      if (32'(fields[F_REL_OFF]) + 4 * 32'(fields[F_REL_CNT]) > image_bytes_reg) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic restart);
    int              rel;
    header_verdict_t verdict;
    if (restart) begin
      position = 0;
      magic_version_good = 1'b1;
      low_hold = '0;
    end
    if (position >= HEADER_BYTES) return;
    if (position < POS_MAGIC_END) begin
      if (b != MAGIC[position]) magic_version_good = 1'b0;
    end else if (position == POS_VERSION_LO) begin
      low_hold = b;
    end else if (position == POS_VERSION_HI) begin
      if ({b, low_hold} != version_reg) magic_version_good = 1'b0;
    end else if (position >= FIELD_FIRST && position < FIELD_END) begin
      rel = position - FIELD_FIRST;
      if (rel % 2 == 0) low_hold = b;
      else fields[rel / 2] = {b, low_hold};
    end
    position++;
    if (position == HEADER_BYTES) begin
      verdict.ok = layout_ok();
      verdict.fields = fields;
      expected_headers.push_back(verdict);
    end
  endtask

  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    if (failures < 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
    failures++;
  endtask

  task automatic check_result();
    header_verdict_t want;
    field_arr_t      got;
    got[F_ENTRY]   = entry_offset;
    got[F_CODE]    = code_bytes;
    got[F_DATA]    = data_bytes;
    got[F_ZFILL]   = zero_fill_bytes;
    got[F_IMP_OFF] = import_table_offset;
    got[F_IMP_CNT] = import_entries;
    got[F_REL_OFF] = reloc_table_offset;
    got[F_REL_CNT] = reloc_entries;
    got[F_STR_OFF] = string_table_offset;
    got[F_STR_LEN] = string_table_bytes;
    if (expected_headers.size() == 0) begin
      if (failures < 10) begin
        $display("result transfer with none pending: header_ok %b entry_offset %h",
                 header_ok, entry_offset);
      end
      failures++;
      return;
    end
    want = expected_headers.pop_front();
    if (header_ok !== want.ok) note_mismatch("header_ok", 16'(want.ok), 16'(header_ok));
    for (int i = 0; i < FIELD_COUNT; i++) begin
      if (got[i] !== want.fields[i]) note_mismatch(field_label[i], want.fields[i], got[i]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      position = 0;
      low_hold = '0;
      magic_version_good = 1'b1;
      fields = '0;
      image_bytes_reg = IMAGE_BYTES_RESET;
      version_reg = FORMAT_VERSION_RESET;
      expected_headers.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_IMAGE_BYTES) image_bytes_reg = pwdata[15:0];
        else version_reg = pwdata[15:0];
      end
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) take_byte(header_byte, first_byte);
    end
    pending <= expected_headers.size();
  end

endmodule

// ----- tb/tb_exec_header_validator.sv -----
// ----------------------------------------------------------------------------
// tb_exec_header_validator
// Streams directed and random executable headers through the validator
// under several register settings, with random gaps on the byte side and
// random stalls on the result side, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_exec_header_validator;
  import ehv_pkg::*;

  localparam int LIMIT        = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 8;

  localparam logic [ADDR_W-1:0] ADDR_IMAGE_BYTES    = {REG_IMAGE_BYTES, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_FORMAT_VERSION = {REG_FORMAT_VERSION, 2'b00};

  typedef enum int {MUT_NONE, MUT_MAGIC, MUT_VERSION, MUT_FIELD} mutation_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [7:0]        header_byte = '0;
  logic              first_byte = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              header_ok;
  logic [15:0]       entry_offset, code_bytes, data_bytes, zero_fill_bytes;
  logic [15:0]       import_table_offset, import_entries, reloc_table_offset;
  logic [15:0]       reloc_entries, string_table_offset, string_table_bytes;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                failures;
  int                pending;

  int          cycles = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          stall_left = 0;
  int          sent_bytes = 0;
  int          headers_sent = 0;
  int          phase_start;
  logic [15:0] cur_image;
  logic [15:0] cur_version;
  logic [7:0]  hdr [HEADER_BYTES];
  logic [15:0] fld [FIELD_COUNT];
  int          img_tab [PHASES] = '{65535, 0, 31, 32, 33, -1, -1, 65535};
  int          ver_tab [PHASES] = '{1, 0, 65535, -1, 1, -1, -1, 65535};

  exec_header_validator dut (
    .clk(clk), .rst(rst), .header_byte(header_byte), .first_byte(first_byte),
    .in_valid(in_valid), .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .header_ok(header_ok), .entry_offset(entry_offset), .code_bytes(code_bytes),
    .data_bytes(data_bytes), .zero_fill_bytes(zero_fill_bytes),
    .import_table_offset(import_table_offset), .import_entries(import_entries),
    .reloc_table_offset(reloc_table_offset), .reloc_entries(reloc_entries),
    .string_table_offset(string_table_offset), .string_table_bytes(string_table_bytes),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  header_result_checker chk (
    .clk(clk), .rst(rst), .header_byte(header_byte), .first_byte(first_byte),
    .in_valid(in_valid), .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .header_ok(header_ok), .entry_offset(entry_offset), .code_bytes(code_bytes),
    .data_bytes(data_bytes), .zero_fill_bytes(zero_fill_bytes),
    .import_table_offset(import_table_offset), .import_entries(import_entries),
    .reloc_table_offset(reloc_table_offset), .reloc_entries(reloc_entries),
    .string_table_offset(string_table_offset), .string_table_bytes(string_table_bytes),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .failures(failures), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0 && $urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 6);
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic restart);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    header_byte <= b;
    first_byte <= restart;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_header(input int count, input logic restart);
    for (int i = 0; i < count; i++) send_byte(hdr[i], (i == 0) ? restart : 1'b0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic make_fields(input logic [15:0] img, input bit plausible, input bit tight);
    int unsigned avail, spare, stop, room, cnt, len;
    for (int i = 0; i < FIELD_COUNT; i++) fld[i] = 16'($urandom);
    if (!plausible || img <= HEADER_BYTES) return;
    avail = img - HEADER_BYTES;
    fld[F_CODE] = 16'($urandom_range(1, avail));
    spare = avail - fld[F_CODE];
    if (tight) fld[F_DATA] = 16'(spare - $urandom_range(0, (spare < 24) ? spare : 24));
    else fld[F_DATA] = 16'($urandom_range(0, spare));
    if (tight) fld[F_ENTRY] = fld[F_CODE] - 16'd1;
    else fld[F_ENTRY] = 16'($urandom_range(0, fld[F_CODE] - 1));
    stop = HEADER_BYTES + 32'(fld[F_CODE]) + 32'(fld[F_DATA]);
    room = img - stop;
    fld[F_IMP_CNT] = '0;
    if (room >= 2 && $urandom_range(0, 2) != 0) begin
      cnt = tight ? room / 2 : $urandom_range(1, room / 2);
      len = tight ? room : $urandom_range(1, room);
      fld[F_IMP_CNT] = 16'(cnt);
      fld[F_IMP_OFF] = 16'(tight ? img - 2 * cnt : $urandom_range(stop, img - 2 * cnt));
      fld[F_STR_LEN] = 16'(len);
      fld[F_STR_OFF] = 16'(tight ? img - len : $urandom_range(stop, img - len));
    end
    fld[F_REL_CNT] = '0;
    if (room >= 4 && $urandom_range(0, 2) != 0) begin
      cnt = tight ? room / 4 : $urandom_range(1, room / 4);
      fld[F_REL_CNT] = 16'(cnt);
      fld[F_REL_OFF] = 16'(tight ? img - 4 * cnt : $urandom_range(stop, img - 4 * cnt));
    end
  endtask

  task automatic pack_header(input mutation_t mut);
    int i;
    int k;
    if (mut == MUT_FIELD) begin
      k = $urandom_range(0, FIELD_COUNT - 1);
      case ($urandom_range(0, 4))
        0: fld[k] = 16'h0000;
        1: fld[k] = 16'hFFFF;
        2: fld[k] = fld[k] + 16'd1;
        3: fld[k] = fld[k] - 16'd1;
        default: fld[k] = 16'($urandom);
      endcase
    end
    for (i = 0; i < HEADER_BYTES; i++) hdr[i] = 8'($urandom);
    for (i = 0; i < 4; i++) hdr[i] = MAGIC[i];
    hdr[POS_VERSION_LO] = cur_version[7:0];
    hdr[POS_VERSION_HI] = cur_version[15:8];
    for (i = 0; i < FIELD_COUNT; i++) begin
      hdr[FIELD_FIRST + 2 * i] = fld[i][7:0];
      hdr[FIELD_FIRST + 2 * i + 1] = fld[i][15:8];
    end
    if (mut == MUT_MAGIC) begin
      k = $urandom_range(0, 3);
      hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
    end else if (mut == MUT_VERSION) begin
      k = $urandom_range(POS_VERSION_LO, POS_VERSION_HI);
      hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
    end
  endtask

  task automatic uniform_header(input logic [7:0] v);
    for (int i = 0; i < FIELD_COUNT; i++) fld[i] = {v, v};
    pack_header(MUT_NONE);
    hdr[6] = v;
    hdr[7] = v;
    for (int i = FIELD_END; i < HEADER_BYTES; i++) hdr[i] = v;
    send_header(HEADER_BYTES, 1'b1);
  endtask

  task automatic send_layout(input logic [15:0] entry, code, data, imp_off, imp_cnt,
                             rel_off, rel_cnt, str_off, str_len);
    fld[F_ENTRY]   = entry;
    fld[F_CODE]    = code;
    fld[F_DATA]    = data;
    fld[F_ZFILL]   = 16'($urandom);
    fld[F_IMP_OFF] = imp_off;
    fld[F_IMP_CNT] = imp_cnt;
    fld[F_REL_OFF] = rel_off;
    fld[F_REL_CNT] = rel_cnt;
    fld[F_STR_OFF] = str_off;
    fld[F_STR_LEN] = str_len;
    pack_header(MUT_NONE);
    send_header(HEADER_BYTES, 1'b1);
  endtask

  task automatic run_directed();
    // The first header after reset arrives without a start flag.
    make_fields(cur_image, 1'b1, 1'b0);
    pack_header(MUT_NONE);
    send_header(HEADER_BYTES, 1'b0);
    make_fields(cur_image, 1'b1, 1'b1);
    pack_header(MUT_NONE);
    send_header(HEADER_BYTES, 1'b1);
    repeat (3) send_byte(8'($urandom), 1'b0);
    uniform_header(8'hFF);
    uniform_header(8'h00);
    send_layout(16'd0, 16'd1, 16'd0, 16'd33, 16'h8000, 16'd0, 16'd0, 16'd33, 16'd1);
    send_layout(16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd33, 16'h4000, 16'd0, 16'd0);
    send_layout(16'd0, 16'h8000, 16'h7FE0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_layout(16'd0, 16'd1, 16'd65502, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_layout(16'd0, 16'd1, 16'd65503, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_layout(16'd0, 16'd1, 16'd0, 16'd33, 16'd32751, 16'd33, 16'd16375, 16'd65534, 16'd1);
    send_layout(16'd5, 16'd5, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    for (int i = 0; i < 4; i++) begin
      make_fields(cur_image, 1'b1, 1'b0);
      pack_header(MUT_NONE);
      hdr[i] = hdr[i] ^ 8'h20;
      send_header(HEADER_BYTES, 1'b1);
    end
    for (int i = POS_VERSION_LO; i <= POS_VERSION_HI; i++) begin
      make_fields(cur_image, 1'b1, 1'b0);
      pack_header(MUT_NONE);
      hdr[i] = hdr[i] ^ 8'h81;
      send_header(HEADER_BYTES, 1'b1);
    end
    make_fields(cur_image, 1'b1, 1'b0);
    pack_header(MUT_NONE);
    send_header(15, 1'b1);
    make_fields(cur_image, 1'b1, 1'b0);
    pack_header(MUT_NONE);
    send_header(HEADER_BYTES, 1'b1);
  endtask

  task automatic run_sequence();
    int        kind;
    mutation_t mut;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: mut = MUT_MAGIC;
      1: mut = MUT_VERSION;
      2, 3, 4: mut = MUT_FIELD;
      default: mut = MUT_NONE;
    endcase
    make_fields(cur_image, kind < 90, $urandom_range(0, 2) == 0);
    pack_header(mut);
    if (kind < 60 || kind >= 90) begin
      send_header(HEADER_BYTES, 1'b1);
      headers_sent++;
    end else if (kind < 70) begin
      send_header(HEADER_BYTES, 1'b1);
      headers_sent++;
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
    end else if (kind < 80) begin
      send_header($urandom_range(1, HEADER_BYTES - 1), 1'b1);
    end else begin
      repeat ($urandom_range(1, 40)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      cur_image = (img_tab[ph] < 0) ? 16'($urandom_range(34, 65535)) : 16'(img_tab[ph]);
      cur_version = (ver_tab[ph] < 0) ? 16'($urandom) : 16'(ver_tab[ph]);
      apb_write(ADDR_IMAGE_BYTES, {16'($urandom), cur_image});
      apb_write(ADDR_FORMAT_VERSION, {16'($urandom), cur_version});
      if (ph == PHASES - 1) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = 15 * $urandom_range(0, 2);
        stall_pct = 15 * $urandom_range(0, 2);
      end
      if (ph == 0) begin
        run_directed();
      end else begin
        headers_sent = 0;
        phase_start = sent_bytes;
        while (sent_bytes - phase_start < 32 || headers_sent < 1) run_sequence();
      end
      drain();
    end
    if (failures == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
